>>> rtl/hns_pkg.sv
// Shared types, constants and helpers for the heightfield normal stream.
`default_nettype none
package hns_pkg;

  localparam int MAX_WIDTH_D   = 128;
  localparam int HEIGHT_BITS_D = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int UNIT_Q14      = 16384;
  localparam int TWO_Q12       = 8192;
  localparam int ROW_LIMIT     = 128;

  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] n;
    logic       wr;
    logic [1:0] wslot;
    logic [6:0] wcol;
    logic [6:0] row;
    logic [6:0] col;
    logic       done;
    logic [1:0] slot_c;
    logic [1:0] slot_d;
    logic [1:0] slot_u;
  } job_t;

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_next(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hns_in_if.sv
// Input request channel: height samples and drain steps.
`default_nettype none
interface hns_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] height;
  modport source (output valid, action, height, input ready);
  modport sink (input valid, action, height, output ready);
endinterface
`default_nettype wire

>>> rtl/hns_out_if.sv
// Output request channel: one unit normal per request.
`default_nettype none
interface hns_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_x;
  logic        [14:0] norm_y;
  logic signed [15:0] norm_z;
  logic        [6:0]  out_row;
  logic        [6:0]  out_col;
  logic               last_of_run;
  logic               grid_done;
  modport source (output valid, norm_x, norm_y, norm_z, out_row, out_col, last_of_run,
                  grid_done, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, out_row, out_col, last_of_run,
                grid_done, output ready);
endinterface
`default_nettype wire

>>> rtl/hns_queue.sv
// Small FIFO between the front classifier and the back normal unit.
`default_nettype none
module hns_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = hns_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  output      logic          full,
  input  wire logic          pop,
  output      logic [DW-1:0] dout,
  output      logic          not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] store [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full      = (count_r == (PW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = store[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/hns_front.sv
// Front end: accepts requests, tracks grid position and queues store writes and normal jobs.
`default_nettype none
module hns_front #(
  parameter int HEIGHT_BITS = hns_pkg::HEIGHT_BITS_D
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  hns_in_if.sink                      in_ch,
  input  wire logic [7:0]             w,
  input  wire logic [7:0]             rows,
  input  wire logic                   restart,
  input  wire logic                   full,
  output      logic                   push,
  output      hns_pkg::job_t          push_job,
  output      logic signed [HEIGHT_BITS-1:0] push_height
);
  logic [6:0] col_r, row_r, drain_r;
  logic [1:0] slot_r;
  logic       draining_r;
  logic       acc, is_sample, is_drain;
  logic [7:0] col_plus, drain_plus;
  logic       row_end, grid_end, drain_end;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_sample   = acc && !in_ch.action && !draining_r;
  assign is_drain    = acc && in_ch.action && draining_r;
  assign push        = is_sample || is_drain;
  assign push_height = HEIGHT_BITS'(in_ch.height);

  assign col_plus   = 8'(col_r) + 8'd1;
  assign drain_plus = 8'(drain_r) + 8'd1;
  assign row_end    = (col_plus >= w);
  assign grid_end   = ((8'(row_r) + 8'd1) >= rows);
  assign drain_end  = (drain_plus >= w);

  always_comb begin
    push_job = '0;
    if (draining_r) begin
      push_job.n      = 2'd1;
      push_job.row    = 7'(rows - 8'd1);
      push_job.col    = drain_r;
      push_job.done   = drain_end;
      push_job.slot_c = slot_r;
      push_job.slot_d = hns_pkg::slot_prev(slot_r);
      push_job.slot_u = slot_r;
    end else begin
      push_job.wr     = 1'b1;
      push_job.wslot  = slot_r;
      push_job.wcol   = col_r;
      push_job.n      = (row_r != '0 && col_r != '0) ? ((col_plus == w) ? 2'd2 : 2'd1)
                                                     : 2'd0;
      push_job.row    = row_r - 7'd1;
      push_job.col    = col_r - 7'd1;
      push_job.slot_c = hns_pkg::slot_prev(slot_r);
      push_job.slot_d = (row_r != 7'd1) ? hns_pkg::slot_prev(hns_pkg::slot_prev(slot_r))
                                        : hns_pkg::slot_prev(slot_r);
      push_job.slot_u = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      slot_r     <= '0;
      draining_r <= 1'b0;
    end else if (is_sample) begin
      if (row_end) begin
        col_r <= '0;
        if (grid_end) begin
          draining_r <= 1'b1;
          drain_r    <= '0;
        end else begin
          row_r  <= row_r + 7'd1;
          slot_r <= hns_pkg::slot_next(slot_r);
        end
      end else begin
        col_r <= col_r + 7'd1;
      end
    end else if (is_drain) begin
      if (drain_end) begin
        col_r      <= '0;
        row_r      <= '0;
        drain_r    <= '0;
        slot_r     <= '0;
        draining_r <= 1'b0;
      end else begin
        drain_r <= drain_r + 7'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/hns_back.sv
// Back end: row store, neighbor fetch, squares and bit-serial normalization of one normal.
`default_nettype none
module hns_back #(
  parameter int MAX_WIDTH   = hns_pkg::MAX_WIDTH_D,
  parameter int HEIGHT_BITS = hns_pkg::HEIGHT_BITS_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire hns_pkg::job_t                 head_job,
  input  wire logic signed [HEIGHT_BITS-1:0] head_height,
  output      logic                          pop,
  input  wire logic [7:0]                    w,
  hns_out_if.source                          out_ch
);
  localparam int HB    = HEIGHT_BITS;
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (2*HB+2 > 28) ? 2*HB+2 : 28;
  localparam int W     = SW + 34;

  typedef enum logic [2:0] {B_IDLE, B_RD, B_SQ, B_SOLVE, B_OUT} bstate_t;

  bstate_t              state_r;
  hns_pkg::job_t        job_r;
  logic                 idx_r;
  logic [2:0]           cnt_r;
  logic [3:0]           j_r;
  logic signed [HB-1:0] store [DEPTH];
  logic signed [HB-1:0] rdata_r, hl_r, hr_r, hd_r;
  logic signed [HB:0]   dx_r, dz_r, mul_in;
  logic signed [2*HB+1:0] prod;
  logic [SW-1:0]        sqx_r, sqz_r, s_r;
  logic [14:0]          m_r [3];
  logic [14:0]          m_nxt [3];
  logic [W-1:0]         a_r [3];
  logic [W-1:0]         a_nxt [3];
  logic [W-1:0]         b_r [3];
  logic [W-1:0]         b_nxt [3];
  logic [W-1:0]         a_try [3];
  logic [W-1:0]         b_try [3];
  logic [W-1:0]         e_try [3];
  logic [W-1:0]         tgt [3];
  logic [14:0]          kx, ky, kz;
  logic [6:0]           cur_col, col_l, col_r_n;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 mem_we;
  logic signed [15:0]   x_r, z_r;
  logic [14:0]          y_r;
  logic                 last_r, done_r;

  function automatic logic [AW-1:0] loc(input logic [1:0] slot, input logic [6:0] col);
    return AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  assign pop     = (state_r == B_IDLE) && head_valid;
  assign mem_we  = pop && head_job.wr;
  assign wr_addr = loc(head_job.wslot, head_job.wcol);

  assign cur_col = job_r.col + 7'(idx_r);
  assign col_l   = (cur_col != '0) ? cur_col - 7'd1 : cur_col;
  assign col_r_n = ((8'(cur_col) + 8'd1) < w) ? cur_col + 7'd1 : cur_col;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    rd_addr = loc(job_r.slot_c, col_l);
      2'd1:    rd_addr = loc(job_r.slot_c, col_r_n);
      2'd2:    rd_addr = loc(job_r.slot_d, cur_col);
      default: rd_addr = loc(job_r.slot_u, cur_col);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= head_height;
    end
    rdata_r <= store[rd_addr];
  end

  assign mul_in = (cnt_r == 3'd0) ? dx_r : dz_r;
  assign prod   = mul_in * mul_in;

  assign tgt[0] = W'(sqx_r) << 30;
  assign tgt[1] = W'(1) << 56;
  assign tgt[2] = W'(sqz_r) << 30;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_try[i] = a_r[i] + (b_r[i] << ({1'b0, j_r} + 5'd1)) + (W'(s_r) << {j_r, 1'b0});
      b_try[i] = b_r[i] + (W'(s_r) << j_r);
      e_try[i] = (a_try[i] << 2) + W'(s_r) - (b_try[i] << 2);
      if (e_try[i] <= tgt[i]) begin
        m_nxt[i] = m_r[i] | (15'd1 << j_r);
        a_nxt[i] = a_try[i];
        b_nxt[i] = b_try[i];
      end else begin
        m_nxt[i] = m_r[i];
        a_nxt[i] = a_r[i];
        b_nxt[i] = b_r[i];
      end
    end
  end

  assign kx = (m_nxt[0] > 15'(hns_pkg::UNIT_Q14)) ? 15'(hns_pkg::UNIT_Q14) : m_nxt[0];
  assign ky = (m_nxt[1] > 15'(hns_pkg::UNIT_Q14)) ? 15'(hns_pkg::UNIT_Q14) : m_nxt[1];
  assign kz = (m_nxt[2] > 15'(hns_pkg::UNIT_Q14)) ? 15'(hns_pkg::UNIT_Q14) : m_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      idx_r   <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (pop && head_job.n != 2'd0) begin
            job_r   <= head_job;
            idx_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= B_RD;
          end
        end
        B_RD: begin
          cnt_r <= cnt_r + 3'd1;
          case (cnt_r)
            3'd1: hl_r <= rdata_r;
            3'd2: hr_r <= rdata_r;
            3'd3: hd_r <= rdata_r;
            3'd4: begin
              dx_r    <= {hl_r[HB-1], hl_r} - {hr_r[HB-1], hr_r};
              dz_r    <= {hd_r[HB-1], hd_r} - {rdata_r[HB-1], rdata_r};
              cnt_r   <= '0;
              state_r <= B_SQ;
            end
            default: ;
          endcase
        end
        B_SQ: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd0) begin
            sqx_r <= SW'($unsigned(prod));
          end else if (cnt_r == 3'd1) begin
            sqz_r <= SW'($unsigned(prod));
          end else begin
            s_r <= sqx_r + sqz_r + SW'(hns_pkg::TWO_Q12 * hns_pkg::TWO_Q12);
            for (int i = 0; i < 3; i++) begin
              m_r[i] <= '0;
              a_r[i] <= '0;
              b_r[i] <= '0;
            end
            j_r     <= 4'd14;
            state_r <= B_SOLVE;
          end
        end
        B_SOLVE: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= m_nxt[i];
            a_r[i] <= a_nxt[i];
            b_r[i] <= b_nxt[i];
          end
          j_r <= j_r - 4'd1;
          if (j_r == 4'd0) begin
            x_r     <= dx_r[HB] ? 16'sd0 - $signed(16'(kx)) : $signed(16'(kx));
            y_r     <= ky;
            z_r     <= dz_r[HB] ? 16'sd0 - $signed(16'(kz)) : $signed(16'(kz));
            last_r  <= idx_r || (job_r.n == 2'd1);
            done_r  <= !idx_r && job_r.done;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ch.ready) begin
            if (!idx_r && job_r.n == 2'd2) begin
              idx_r   <= 1'b1;
              cnt_r   <= '0;
              state_r <= B_RD;
            end else begin
              state_r <= B_IDLE;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = (state_r == B_OUT);
  assign out_ch.norm_x      = x_r;
  assign out_ch.norm_y      = y_r;
  assign out_ch.norm_z      = z_r;
  assign out_ch.out_row     = job_r.row;
  assign out_ch.out_col     = cur_col;
  assign out_ch.last_of_run = last_r;
  assign out_ch.grid_done   = done_r;

`ifndef SYNTH
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT) |-> (y_r <= 15'(hns_pkg::UNIT_Q14)))
    else $error("normal y out of range");
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT) |-> (x_r <= 16'sd16384 && x_r >= -16'sd16384))
    else $error("normal x out of range");
  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_ch.ready && !idx_r && job_r.n == 2'd2) |=> (state_r == B_RD))
    else $error("row-end second normal skipped");
`endif
endmodule
`default_nettype wire

>>> rtl/heightfield_normal_stream.sv
// Top level: configuration registers, front end, job queue and normal unit.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | action, height
//  out_ch   | out | valid/ready      | norm_x, norm_y, norm_z, out_row, out_col, flags
//  cfg      | in  | APB psel/penable | row_width @0x0, row_count @0x4
//
// Front takes one request per cycle while the queue has room.
// In the back unit a normal is popped, its four store reads go through one read port,
// squares and sum are formed, a bit-serial divide/sqrt runs, and the result is handed off.
// Row-end samples carry two normals in one job; the second is computed without a new pop.
// A stalled out_ch holds the back unit; once the queue fills, in_ch is held too.
// Synchronous active-low reset; row store contents are not cleared.
`default_nettype none
module heightfield_normal_stream #(
  parameter int MAX_WIDTH   = hns_pkg::MAX_WIDTH_D,
  parameter int HEIGHT_BITS = hns_pkg::HEIGHT_BITS_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hns_in_if.sink           in_ch,
  hns_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  localparam int TOP_W = (MAX_WIDTH < hns_pkg::ROW_LIMIT) ? MAX_WIDTH : hns_pkg::ROW_LIMIT;
  localparam int DW    = $bits(hns_pkg::job_t) + HEIGHT_BITS;

  logic [7:0] row_width_r, row_count_r, w_eff, rows_eff;
  logic       cfg_we;
  logic       push, full, pop, not_empty;
  hns_pkg::job_t push_job, head_job;
  logic signed [HEIGHT_BITS-1:0] push_height, head_height;
  logic [DW-1:0] head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = {24'd0, (paddr[2] == hns_pkg::REG_ROW_COUNT) ? row_count_r : row_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= 8'd128;
      row_count_r <= 8'd128;
    end else if (cfg_we) begin
      if (paddr[2] == hns_pkg::REG_ROW_WIDTH) begin
        row_width_r <= pwdata[7:0];
      end else begin
        row_count_r <= pwdata[7:0];
      end
    end
  end

  assign w_eff    = (row_width_r < 8'd2) ? 8'd2 :
                    (row_width_r > 8'(TOP_W)) ? 8'(TOP_W) : row_width_r;
  assign rows_eff = (row_count_r < 8'd2) ? 8'd2 :
                    (row_count_r > 8'(hns_pkg::ROW_LIMIT)) ? 8'(hns_pkg::ROW_LIMIT)
                                                           : row_count_r;

  hns_front #(.HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .w           (w_eff),
    .rows        (rows_eff),
    .restart     (cfg_we),
    .full        (full),
    .push        (push),
    .push_job    (push_job),
    .push_height (push_height)
  );

  hns_queue #(.DW(DW), .DEPTH(hns_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       ({push_height, push_job}),
    .full      (full),
    .pop       (pop),
    .dout      (head),
    .not_empty (not_empty)
  );

  assign head_job    = head[$bits(hns_pkg::job_t)-1:0];
  assign head_height = head[DW-1:$bits(hns_pkg::job_t)];

  hns_back #(.MAX_WIDTH(MAX_WIDTH), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (not_empty),
    .head_job    (head_job),
    .head_height (head_height),
    .pop         (pop),
    .w           (w_eff),
    .out_ch      (out_ch)
  );
endmodule
`default_nettype wire
